### sv/pnps_pkg.sv
// Shared types, widths and codes for the periodic nearest-point select block.
// No dependencies; imported by every module of the block.
`default_nettype none

package pnps_pkg;

   localparam int COORD_BITS = 24;
   localparam int INDEX_BITS = 24;

   localparam int COORD_W = 24;
   localparam int IDX_W   = 24;
   localparam int DIST_W  = 52;
   localparam int BOX_W   = 25;

   localparam int DIFF_W = COORD_BITS + 1;
   localparam int WRAP_W = ((COORD_BITS > BOX_W) ? COORD_BITS : BOX_W) + 2;
   localparam int MAG_W  = WRAP_W - 1;
   localparam int SQ_W   = 2 * MAG_W;
   localparam int SUM_W  = SQ_W + 2;

   localparam int X_LSB      = 0;
   localparam int RADIUS_LSB = 3 * COORD_W;
   localparam int PRIOR_LSB  = RADIUS_LSB + DIST_W;
   localparam int INDEX_LSB  = PRIOR_LSB + DIST_W;
   localparam int ID_BIT     = INDEX_LSB + IDX_W;
   localparam int MASS_BIT   = ID_BIT + 1;
   localparam int REQ_PACK_W = MASS_BIT + 1;
   localparam int REQ_DATA_W = ((REQ_PACK_W + 7) / 8) * 8;

   localparam int RSP_PACK_W = IDX_W + DIST_W;
   localparam int RSP_DATA_W = ((RSP_PACK_W + 7) / 8) * 8;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = BOX_W;

   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = QPTR_W + 1;

   localparam logic [BOX_W-1:0]  BOX_RESET = BOX_W'(16777216);
   localparam logic [DIST_W-1:0] DIST_MAX  = {DIST_W{1'b1}};
   localparam logic [IDX_W-1:0]  INDEX_MASK =
      (INDEX_BITS >= IDX_W) ? {IDX_W{1'b1}} : IDX_W'((64'd1 << INDEX_BITS) - 64'd1);

   localparam logic ACT_BEGIN     = 1'b0;
   localparam logic ACT_CANDIDATE = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BOX_SIZE_X = 2'd0,
      CSR_BOX_SIZE_Y = 2'd1,
      CSR_BOX_SIZE_Z = 2'd2
   } csr_index_type;

   typedef logic [2:0][BOX_W-1:0] box_type;

   typedef struct packed {
      logic              is_begin;
      logic [DIST_W-1:0] radius_sq;
      logic [DIST_W-1:0] prior_sq;
      logic [IDX_W-1:0]  index;
      logic              eligible;
      logic              last;
   } meta_type;

   typedef struct packed {
      meta_type                 meta;
      logic [2:0][DIFF_W-1:0]   diff;
   } entry_type;

endpackage

`default_nettype wire

### sv/pnps_queue.sv
// Short transaction queue between the front and back parts.
// Depends on pnps_pkg for the entry type and depth.
`default_nettype none

module pnps_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push_valid,
   output logic                     push_ready,
   input  wire pnps_pkg::entry_type push_data,
   output logic                     pop_valid,
   input  wire logic                pop_ready,
   output pnps_pkg::entry_type      pop_data
);
   import pnps_pkg::*;

   entry_type          store_ff [QDEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               push, pop;

   assign push_ready = (count_ff != QCNT_W'(QDEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_tracks_push : assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count missed a push");

endmodule

`default_nettype wire

### sv/pnps_front.sv
// Front part: accepts request transactions, latches the query point on begin,
// classifies candidates and forms per-axis differences. Depends on pnps_pkg.
`default_nettype none

module pnps_front (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [pnps_pkg::REQ_DATA_W-1:0] req_tdata,
   input  wire logic                            req_tuser,
   input  wire logic                            req_tlast,
   output logic                                 push_valid,
   input  wire logic                            push_ready,
   output pnps_pkg::entry_type                  push_data
);
   import pnps_pkg::*;

   logic [2:0][COORD_BITS-1:0] query_ff, query_in;
   logic [2:0][COORD_BITS-1:0] coord;
   logic                       is_begin;

   assign req_tready = push_ready;
   assign push_valid = req_tvalid;
   assign is_begin   = (req_tuser == ACT_BEGIN);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         coord[i] = req_tdata[X_LSB + i * COORD_W +: COORD_BITS];
         push_data.diff[i] = {1'b0, query_ff[i]} - {1'b0, coord[i]};
      end
      push_data.meta.is_begin  = is_begin;
      push_data.meta.radius_sq = req_tdata[RADIUS_LSB +: DIST_W];
      push_data.meta.prior_sq  = req_tdata[PRIOR_LSB +: DIST_W];
      push_data.meta.index     = req_tdata[INDEX_LSB +: IDX_W] & INDEX_MASK;
      push_data.meta.eligible  = req_tdata[ID_BIT] && req_tdata[MASS_BIT];
      push_data.meta.last      = req_tlast;

      query_in = query_ff;
      if (req_tvalid && push_ready && is_begin) begin
         query_in = coord;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         query_ff <= '0;
      end else begin
         query_ff <= query_in;
      end
   end

endmodule

`default_nettype wire

### sv/pnps_back.sv
// Back part: periodic wrap, squares, saturating sum, running-best compare and
// the result register. Depends on pnps_pkg.
`default_nettype none

module pnps_back (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire pnps_pkg::box_type           box,
   input  wire logic                        pop_valid,
   output logic                             pop_ready,
   input  wire pnps_pkg::entry_type         pop_data,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic [pnps_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                             rsp_tuser
);
   import pnps_pkg::*;

   function automatic logic [WRAP_W-1:0] wrap_down(input logic [WRAP_W-1:0] d,
                                                   input logic [BOX_W-1:0] b);
      logic signed [WRAP_W:0]   twice;
      logic signed [WRAP_W:0]   bs;
      logic signed [WRAP_W-1:0] bw;
      twice = signed'({d, 1'b0});
      bs    = signed'({{(WRAP_W + 1 - BOX_W){1'b0}}, b});
      bw    = signed'({{(WRAP_W - BOX_W){1'b0}}, b});
      return (twice > bs) ? d - bw : d;
   endfunction

   function automatic logic [WRAP_W-1:0] wrap_up(input logic [WRAP_W-1:0] d,
                                                 input logic [BOX_W-1:0] b);
      logic signed [WRAP_W:0]   twice;
      logic signed [WRAP_W:0]   bs;
      logic signed [WRAP_W-1:0] bw;
      twice = signed'({d, 1'b0});
      bs    = signed'({{(WRAP_W + 1 - BOX_W){1'b0}}, b});
      bw    = signed'({{(WRAP_W - BOX_W){1'b0}}, b});
      return (twice < -bs) ? d + bw : d;
   endfunction

   logic                     adv;
   logic                     s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   meta_type                 s1_meta_ff, s2_meta_ff, s3_meta_ff, s4_meta_ff;
   logic [2:0][WRAP_W-1:0]   s1_d_ff, s1_d_in;
   logic [2:0][MAG_W-1:0]    s2_mag_ff, s2_mag_in;
   logic [2:0][SQ_W-1:0]     s3_sq_ff, s3_sq_in;
   logic [DIST_W-1:0]        s4_dist_ff, s4_dist_in;
   logic [SUM_W-1:0]         sum;
   logic [WRAP_W-1:0]        ext, d2, neg;

   logic [DIST_W-1:0]        limit_ff, limit_in;
   logic [DIST_W-1:0]        best_ff, best_in;
   logic [IDX_W-1:0]         best_idx_ff, best_idx_in;
   logic                     have_ff, have_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     found_ff, found_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic [DIST_W-1:0]        sq_ff, sq_in;

   assign adv       = !rsp_valid_ff || rsp_tready;
   assign pop_ready = adv;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ext = {{(WRAP_W - DIFF_W){pop_data.diff[i][DIFF_W-1]}}, pop_data.diff[i]};
         s1_d_in[i] = wrap_down(ext, box[i]);
         d2  = wrap_up(s1_d_ff[i], box[i]);
         neg = -d2;
         s2_mag_in[i] = d2[WRAP_W-1] ? neg[MAG_W-1:0] : d2[MAG_W-1:0];
         s3_sq_in[i]  = s2_mag_ff[i] * s2_mag_ff[i];
      end
      sum = SUM_W'(s3_sq_ff[0]) + SUM_W'(s3_sq_ff[1]) + SUM_W'(s3_sq_ff[2]);
      s4_dist_in = (sum > SUM_W'(DIST_MAX)) ? DIST_MAX : sum[DIST_W-1:0];
   end

   always_comb begin
      limit_in    = limit_ff;
      best_in     = best_ff;
      best_idx_in = best_idx_ff;
      have_in     = have_ff;
      if (s4_valid_ff && adv) begin
         if (s4_meta_ff.is_begin) begin
            limit_in    = s4_meta_ff.radius_sq;
            best_in     = s4_meta_ff.prior_sq;
            best_idx_in = '0;
            have_in     = 1'b0;
         end else if (s4_meta_ff.eligible && s4_dist_ff < best_ff
                      && s4_dist_ff < limit_ff) begin
            best_in     = s4_dist_ff;
            best_idx_in = s4_meta_ff.index;
            have_in     = 1'b1;
         end
      end

      rsp_valid_in = rsp_valid_ff;
      found_in     = found_ff;
      idx_in       = idx_ff;
      sq_in        = sq_ff;
      if (adv) begin
         rsp_valid_in = s4_valid_ff && s4_meta_ff.last;
         found_in     = have_in;
         idx_in       = have_in ? best_idx_in : '0;
         sq_in        = have_in ? best_in : DIST_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         limit_ff     <= '0;
         best_ff      <= DIST_MAX;
         best_idx_ff  <= '0;
         have_ff      <= 1'b0;
      end else begin
         if (adv) begin
            s1_valid_ff <= pop_valid;
            s2_valid_ff <= s1_valid_ff;
            s3_valid_ff <= s2_valid_ff;
            s4_valid_ff <= s3_valid_ff;
         end
         rsp_valid_ff <= rsp_valid_in;
         limit_ff     <= limit_in;
         best_ff      <= best_in;
         best_idx_ff  <= best_idx_in;
         have_ff      <= have_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_meta_ff <= pop_data.meta;
         s1_d_ff    <= s1_d_in;
         s2_meta_ff <= s1_meta_ff;
         s2_mag_ff  <= s2_mag_in;
         s3_meta_ff <= s2_meta_ff;
         s3_sq_ff   <= s3_sq_in;
         s4_meta_ff <= s3_meta_ff;
         s4_dist_ff <= s4_dist_in;
      end
      found_ff <= found_in;
      idx_ff   <= idx_in;
      sq_ff    <= sq_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = found_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - RSP_PACK_W){1'b0}}, sq_ff, idx_ff};

   a_best_inside_radius : assert property (@(posedge clock) disable iff (reset)
      have_ff |-> best_ff < limit_ff)
      else $error("kept candidate lies outside the search radius");

   a_last_gives_result : assert property (@(posedge clock) disable iff (reset)
      s4_valid_ff && adv && s4_meta_ff.last |=> rsp_valid_ff)
      else $error("last transaction produced no result");

   a_not_found_clean : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !found_ff |-> idx_ff == '0 && sq_ff == DIST_MAX)
      else $error("not-found result carries stale fields");

endmodule

`default_nettype wire

### sv/periodic_nearest_point_select_core.sv
// Throughput: one transaction per cycle while the queue has room; a 4-entry queue
// lets the front keep accepting while the result register waits on rsp_tready.
// Back pipeline: wrap, second wrap and magnitude, square, sum, best compare.
// Reset: synchronous; query and radius clear, best distance goes to all ones,
// box sizes return to 16777216. No clearing pass.
`default_nettype none

module periodic_nearest_point_select_core (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // x, y, z, radius_sq, prior_best_sq, cand_index, id_nonzero, mass_positive
   input  wire logic [pnps_pkg::REQ_DATA_W-1:0] req_tdata,
   // action
   input  wire logic                            req_tuser,
   input  wire logic                            req_tlast,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // nearest_index, nearest_sq
   output logic [pnps_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // found
   output logic                                 rsp_tuser,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   input  wire logic                            csr_we,
   input  wire logic [pnps_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [pnps_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import pnps_pkg::*;

   box_type   box_ff, box_in;
   entry_type push_data, pop_data;
   logic      push_valid, push_ready, pop_valid, pop_ready;

   always_comb begin
      box_in = box_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_BOX_SIZE_X: box_in[0] = csr_wdata;
            CSR_BOX_SIZE_Y: box_in[1] = csr_wdata;
            CSR_BOX_SIZE_Z: box_in[2] = csr_wdata;
            default:        box_in = box_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         box_ff <= {3{BOX_RESET}};
      end else begin
         box_ff <= box_in;
      end
   end

   pnps_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   pnps_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   pnps_back u_back (
      .clock      (clock),
      .reset      (reset),
      .box        (box_ff),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

### tb/periodic_nearest_point_select_core_tb.sv
// Self-checking bench for periodic_nearest_point_select_core: scores each result against
// a cycle-free model of the query state and minimum-image distance, under varied box sizes.
// Depends on pnps_pkg for widths, action codes and register indexes.
`default_nettype none

module periodic_nearest_point_select_core_tb;
   import pnps_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_NO_REGISTER = 2'd3;
   localparam logic [COORD_W-1:0]   COORD_MAX       = '1;

   typedef struct {
      logic              action;
      logic [COORD_W-1:0] x, y, z;
      logic [DIST_W-1:0] radius_sq, prior_sq;
      logic [IDX_W-1:0]  index;
      logic              id_ok, mass_ok, last;
   } point_item_type;

   typedef struct {
      logic              found;
      logic [IDX_W-1:0]  index;
      logic [DIST_W-1:0] dist_sq;
   } nearest_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = ACT_BEGIN;
   logic                  req_tlast  = 1'b0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = CSR_BOX_SIZE_X;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   logic [BOX_W-1:0]   box_len [3] = '{BOX_RESET, BOX_RESET, BOX_RESET};
   logic [COORD_W-1:0] query_pos [3] = '{'0, '0, '0};
   logic [DIST_W-1:0]  radius_limit = '0;
   logic [DIST_W-1:0]  best_dist    = DIST_MAX;
   logic [IDX_W-1:0]   best_idx     = '0;
   logic               best_valid   = 1'b0;
   nearest_type        nearest_expected [$];

   int unsigned idle_pct     = 0;
   int unsigned stall_pct    = 0;
   int unsigned items_sent   = 0;
   int unsigned results_seen = 0;
   int unsigned found_seen   = 0;
   int unsigned writes_done  = 0;
   int unsigned fail_count   = 0;

   periodic_nearest_point_select_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   function automatic longint unsigned wrapped_axis_sq(input logic [COORD_W-1:0] q,
                                                       input logic [COORD_W-1:0] c,
                                                       input logic [BOX_W-1:0] len);
      longint d;
      longint b;
      d = $signed({40'd0, q}) - $signed({40'd0, c});
      b = $signed({39'd0, len});
      if (2 * d > b) d = d - b;
      if (2 * d < -b) d = d + b;
      if (d < 0) d = -d;
      return longint'(d * d);
   endfunction

   task automatic judge_item(input point_item_type it);
      longint unsigned total;
      nearest_type want;
      if (it.action == ACT_BEGIN) begin
         query_pos[0] = it.x;
         query_pos[1] = it.y;
         query_pos[2] = it.z;
         radius_limit = it.radius_sq;
         best_dist    = it.prior_sq;
         best_idx     = '0;
         best_valid   = 1'b0;
      end else begin
         total = wrapped_axis_sq(query_pos[0], it.x, box_len[0])
               + wrapped_axis_sq(query_pos[1], it.y, box_len[1])
               + wrapped_axis_sq(query_pos[2], it.z, box_len[2]);
         if (total > 64'(DIST_MAX)) total = 64'(DIST_MAX);
         if (total < 64'(best_dist) && total < 64'(radius_limit) && it.id_ok && it.mass_ok) begin
            best_dist  = DIST_W'(total);
            best_idx   = it.index;
            best_valid = 1'b1;
         end
      end
      if (it.last) begin
         want.found   = best_valid;
         want.index   = best_valid ? best_idx : '0;
         want.dist_sq = best_valid ? best_dist : DIST_MAX;
         nearest_expected.push_back(want);
      end
   endtask

   always @(posedge clock) begin
      nearest_type want;
      logic [IDX_W-1:0]  got_index;
      logic [DIST_W-1:0] got_sq;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_index = rsp_tdata[IDX_W-1:0];
         got_sq    = rsp_tdata[IDX_W +: DIST_W];
         results_seen++;
         if (rsp_tuser) found_seen++;
         if (nearest_expected.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("unexpected result: found=%0d index=%0h sq=%0h",
                        rsp_tuser, got_index, got_sq);
         end else begin
            want = nearest_expected.pop_front();
            if (rsp_tuser !== want.found || got_index !== want.index
                || got_sq !== want.dist_sq) begin
               fail_count++;
               if (fail_count <= 10)
                  $display({"mismatch: expected found=%0d index=%0h sq=%0h,",
                            " got found=%0d index=%0h sq=%0h"},
                           want.found, want.index, want.dist_sq, rsp_tuser, got_index, got_sq);
            end
         end
      end
   end

   task automatic send_item(input point_item_type it);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.action;
      req_tlast  <= it.last;
      req_tdata  <= REQ_DATA_W'({it.mass_ok, it.id_ok, it.index, it.prior_sq, it.radius_sq,
                                 it.z, it.y, it.x});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      judge_item(it);
      items_sent++;
   endtask

   function automatic logic [DIST_W-1:0] random_dist();
      return DIST_W'({$urandom(), $urandom()});
   endfunction

   task automatic begin_query(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                              input logic [COORD_W-1:0] z, input logic [DIST_W-1:0] radius_sq,
                              input logic [DIST_W-1:0] prior_sq, input logic last);
      point_item_type it;
      it = '{ACT_BEGIN, x, y, z, radius_sq, prior_sq, IDX_W'($urandom()),
             1'($urandom_range(1)), 1'($urandom_range(1)), last};
      send_item(it);
   endtask

   task automatic offer(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                        input logic [COORD_W-1:0] z, input logic [IDX_W-1:0] index,
                        input logic id_ok, input logic mass_ok, input logic last);
      point_item_type it;
      it = '{ACT_CANDIDATE, x, y, z, random_dist(), random_dist(), index, id_ok, mass_ok, last};
      send_item(it);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (nearest_expected.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_boxes(input logic [BOX_W-1:0] x_len, input logic [BOX_W-1:0] y_len,
                            input logic [BOX_W-1:0] z_len, input logic poke_unused);
      logic [CSR_IDX_W-1:0] order [4];
      logic [BOX_W-1:0]     value [4];
      int                   count;
      order = '{CSR_BOX_SIZE_X, CSR_BOX_SIZE_Y, CSR_BOX_SIZE_Z, CSR_NO_REGISTER};
      value = '{x_len, y_len, z_len, BOX_W'($urandom())};
      count = poke_unused ? 4 : 3;
      settle();
      for (int i = 0; i < count; i++) begin
         csr_we    <= 1'b1;
         csr_index <= order[i];
         csr_wdata <= value[i];
         @(posedge clock);
         case (order[i])
            CSR_BOX_SIZE_X: box_len[0] = value[i];
            CSR_BOX_SIZE_Y: box_len[1] = value[i];
            CSR_BOX_SIZE_Z: box_len[2] = value[i];
            default: ;
         endcase
         writes_done++;
      end
      csr_we <= 1'b0;
   endtask

   function automatic logic [DIST_W-1:0] pick_radius();
      case ($urandom_range(3))
         0:       return DIST_MAX;
         1:       return random_dist();
         2:       return DIST_W'(1) << $urandom_range(50);
         default: return DIST_W'($urandom_range(5000));
      endcase
   endfunction

   function automatic logic [BOX_W-1:0] pick_box();
      case ($urandom_range(5))
         0:       return BOX_RESET;
         1:       return BOX_W'($urandom_range(1, 16777216));
         2:       return BOX_W'($urandom_range(1, 64));
         3:       return BOX_W'($urandom_range(16777216, 33554431));
         4:       return BOX_W'($urandom_range(1, 4096));
         default: return '0;
      endcase
   endfunction

   function automatic logic [COORD_W-1:0] near_coord(input logic [COORD_W-1:0] q);
      logic [COORD_W-1:0] off;
      if ($urandom_range(3) == 0) return COORD_W'($urandom());
      off = COORD_W'($urandom_range(0, 1 << $urandom_range(23)));
      return $urandom_range(1) ? q + off : q - off;
   endfunction

   task automatic run_queries(input int unsigned count);
      int unsigned        stop;
      int unsigned        kind;
      int unsigned        n;
      logic [COORD_W-1:0] q [3];
      stop = items_sent + count;
      while (items_sent < stop) begin
         kind = $urandom_range(99);
         if (kind < 8) begin
            offer(COORD_W'($urandom()), COORD_W'($urandom()), COORD_W'($urandom()),
                  IDX_W'($urandom()), 1'($urandom_range(1)), 1'($urandom_range(1)),
                  1'($urandom_range(1)));
         end else if (kind < 12) begin
            begin_query(COORD_W'($urandom()), COORD_W'($urandom()), COORD_W'($urandom()),
                        random_dist(), random_dist(), 1'b1);
         end else begin
            foreach (q[a]) q[a] = COORD_W'($urandom());
            begin_query(q[0], q[1], q[2], pick_radius(),
                        ($urandom_range(3) == 0) ? pick_radius() : DIST_MAX, 1'b0);
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++)
               offer(near_coord(q[0]), near_coord(q[1]), near_coord(q[2]), IDX_W'($urandom()),
                     $urandom_range(99) < 88, $urandom_range(99) < 88, i == n - 1);
            if ($urandom_range(9) == 0)
               offer(near_coord(q[0]), near_coord(q[1]), near_coord(q[2]), IDX_W'($urandom()),
                     1'b1, 1'b1, 1'($urandom_range(1)));
         end
      end
   endtask

   task automatic test_directed();
      offer(24'd5, 24'd5, 24'd5, 24'd7, 1'b1, 1'b1, 1'b1);
      begin_query('0, '0, '0, DIST_MAX, DIST_MAX, 1'b1);
      offer(24'h800000, '0, '0, 24'd1, 1'b1, 1'b1, 1'b0);
      offer(24'h800001, '0, '0, 24'd2, 1'b1, 1'b1, 1'b0);
      offer(COORD_MAX, '0, '0, 24'hFFFFFF, 1'b1, 1'b1, 1'b0);
      offer(24'd1, '0, '0, '0, 1'b1, 1'b1, 1'b0);
      offer('0, '0, '0, 24'd5, 1'b0, 1'b1, 1'b0);
      offer('0, '0, '0, 24'd6, 1'b1, 1'b0, 1'b1);
      offer('0, '0, '0, 24'd9, 1'b1, 1'b1, 1'b1);
      begin_query(COORD_MAX, COORD_MAX, COORD_MAX, '0, DIST_MAX, 1'b0);
      offer(COORD_MAX, COORD_MAX, COORD_MAX, 24'd3, 1'b1, 1'b1, 1'b1);
      begin_query(COORD_MAX, COORD_MAX, COORD_MAX, DIST_MAX, 52'd100, 1'b0);
      offer('0, '0, '0, 24'd4, 1'b1, 1'b1, 1'b0);
      offer(COORD_MAX - 24'd10, COORD_MAX, COORD_MAX, 24'd8, 1'b1, 1'b1, 1'b1);
      begin_query(24'd1000, 24'd2000, 24'd3000, 52'd49, DIST_MAX, 1'b0);
      offer(24'd1007, 24'd2000, 24'd3000, 24'd11, 1'b1, 1'b1, 1'b0);
      offer(24'd1000, 24'd2003, 24'd3004, 24'd12, 1'b1, 1'b1, 1'b1);
      begin_query(COORD_W'($urandom()), COORD_W'($urandom()), COORD_W'($urandom()),
                  random_dist(), random_dist(), 1'b1);
   endtask

   task automatic test_box_extremes();
      set_boxes(25'd1, 25'd1, 25'd1, 1'b0);
      run_queries(20);
      set_boxes('1, '1, '1, 1'b0);
      run_queries(20);
      set_boxes('0, '0, '0, 1'b0);
      run_queries(20);
      set_boxes(BOX_RESET, 25'd1, 25'd3, 1'b1);
      run_queries(20);
   endtask

   task automatic test_traffic_phases();
      int unsigned sender_idle [4] = '{0, 73, 0, 18};
      int unsigned sink_stall [4]  = '{0, 0, 73, 18};
      for (int p = 0; p < 4; p++) begin
         set_boxes(pick_box(), pick_box(), pick_box(), 1'b0);
         idle_pct  = sender_idle[p];
         stall_pct = sink_stall[p];
         run_queries(115);
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_box_extremes();
      test_traffic_phases();
      settle();
      fail_count += nearest_expected.size();
      $display("sent %0d transactions across 4 traffic phases and %0d register writes",
               items_sent, writes_done);
      $display("checked %0d results, %0d with a nearest point found", results_seen, found_seen);
      if (fail_count == 0) begin
         $display("periodic_nearest_point_select_core_tb OK");
      end else begin
         $display("periodic_nearest_point_select_core_tb NOT OK");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("timeout after %0d transactions", items_sent);
      $display("periodic_nearest_point_select_core_tb NOT OK");
      $finish;
   end

endmodule

`default_nettype wire

### filelist.f
sv/pnps_pkg.sv
sv/pnps_queue.sv
sv/pnps_front.sv
sv/pnps_back.sv
sv/periodic_nearest_point_select_core.sv
tb/periodic_nearest_point_select_core_tb.sv
